/* src/jsld_pkg.sv */
// Shared types, constants and helper functions of the JSON string literal decoder.
// Used by jsld_step and json_string_literal_decoder; depends on nothing else.
package jsld_pkg;

    localparam int LENGTH_BITS_DEF = 24;
    localparam int LEN_W           = 24;
    localparam int CFG_W           = 24;
    localparam int MAX_RESULTS     = 4;
    localparam int RES_CNT_W       = 3;
    localparam int RES_IDX_W       = 2;

    localparam logic [CFG_W-1:0] MAX_BYTES_RESET = 24'd65535;

    // Source characters that steer the decoder.
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_LOW_B   = 8'h62;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CH_LOW_N   = 8'h6e;
    localparam logic [7:0] CH_LOW_R   = 8'h72;
    localparam logic [7:0] CH_LOW_T   = 8'h74;
    localparam logic [7:0] CH_LOW_U   = 8'h75;
    localparam logic [7:0] CH_CTRL_LIM = 8'h20;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_FF      = 8'h0c;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_TAB     = 8'h09;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_BODY    = 3'd1,
        M_ESC     = 3'd2,
        M_HEX     = 3'd3,
        M_WANT_BS = 3'd4,
        M_WANT_U  = 3'd5,
        M_LOW_HEX = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_QUOTE = 3'd1,
        ST_CONTROL  = 3'd2,
        ST_UNTERM   = 3'd3,
        ST_BAD_ESC  = 3'd4,
        ST_BAD_HEX  = 3'd5,
        ST_UTF8     = 3'd6,
        ST_TOO_LONG = 3'd7
    } t_status;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_END  = 1'b1
    } t_op;

    typedef enum logic {
        K_BYTE   = 1'b0,
        K_STATUS = 1'b1
    } t_kind;

    // Running UTF-8 validator.
    typedef struct packed {
        logic [1:0]  need;
        logic [1:0]  lead;
        logic [20:0] point;
        logic        bad;
    } t_utf;

    // Per-string decoder context, byte count excluded.
    typedef struct packed {
        t_mode       mode;
        logic [1:0]  hex_cnt;
        logic [15:0] hex_val;
        logic [9:0]  high;
        t_utf        utf;
        logic        too_long;
    } t_ctx;

    localparam t_ctx CTX_CLEAR = '{
        mode: M_IDLE, hex_cnt: 2'd0, hex_val: 16'd0, high: 10'd0,
        utf: '{need: 2'd0, lead: 2'd0, point: 21'd0, bad: 1'b0},
        too_long: 1'b0
    };

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        data;
        t_status           status;
        logic [LEN_W-1:0]  length;
    } t_result;

    typedef struct packed {
        logic [RES_CNT_W-1:0] n;
        logic [3:0][7:0]      b;
    } t_enc;

    function automatic t_utf utf_step(t_utf s, logic [7:0] b);
        t_utf r;
        r = s;
        if (!s.bad) begin
            if (s.need != 2'd0) begin
                if (b[7:6] != 2'b10) begin
                    r.bad = 1'b1;
                end else begin
                    r.point = {s.point[14:0], b[5:0]};
                    r.need  = s.need - 2'd1;
                    if (r.need == 2'd0) begin
                        if (r.point >= 21'h00d800 && r.point <= 21'h00dfff) r.bad = 1'b1;
                        if (s.lead == 2'd2 && r.point < 21'h000800) r.bad = 1'b1;
                        if (s.lead == 2'd3 && r.point < 21'h010000) r.bad = 1'b1;
                        if (r.point > 21'h10ffff) r.bad = 1'b1;
                    end
                end
            end else if (b[7]) begin
                if (b[7:5] == 3'b110) begin
                    r.point = {16'd0, b[4:0]};
                    // Leads 0xC0 and 0xC1 can only start an overlong form.
                    if (b[4:1] == 4'd0) begin
                        r.bad = 1'b1;
                    end else begin
                        r.need = 2'd1;
                        r.lead = 2'd1;
                    end
                end else if (b[7:4] == 4'b1110) begin
                    r.point = {17'd0, b[3:0]};
                    r.need  = 2'd2;
                    r.lead  = 2'd2;
                end else if (b[7:3] == 5'b11110) begin
                    r.point = {18'd0, b[2:0]};
                    r.need  = 2'd3;
                    r.lead  = 2'd3;
                end else begin
                    r.bad = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic t_enc utf8_encode(logic [20:0] cp);
        t_enc e;
        e.n = 3'd0;
        e.b = '0;
        if (cp <= 21'h00007f) begin
            e.n    = 3'd1;
            e.b[0] = cp[7:0];
        end else if (cp <= 21'h0007ff) begin
            e.n    = 3'd2;
            e.b[0] = {3'b110, cp[10:6]};
            e.b[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'h00ffff) begin
            e.n    = 3'd3;
            e.b[0] = {4'b1110, cp[15:12]};
            e.b[1] = {2'b10, cp[11:6]};
            e.b[2] = {2'b10, cp[5:0]};
        end else begin
            e.n    = 3'd4;
            e.b[0] = {5'b11110, cp[20:18]};
            e.b[1] = {2'b10, cp[17:12]};
            e.b[2] = {2'b10, cp[11:6]};
            e.b[3] = {2'b10, cp[5:0]};
        end
        return e;
    endfunction

    // Returns {valid, value}.
    function automatic logic [4:0] hex_digit(logic [7:0] h);
        logic [7:0] t;
        t = 8'd0;
        if (h >= 8'h30 && h <= 8'h39) begin
            t = h - 8'h30;
            return {1'b1, t[3:0]};
        end else if (h >= 8'h61 && h <= 8'h66) begin
            t = h - 8'h57;
            return {1'b1, t[3:0]};
        end else if (h >= 8'h41 && h <= 8'h46) begin
            t = h - 8'h37;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

/* src/jsld_step.sv */
// One-beat decode step: next context, byte count and result group for one source beat.
// Purely combinational; depends on jsld_pkg.
module jsld_step #(
    parameter int LENGTH_BITS = jsld_pkg::LENGTH_BITS_DEF
) (
    input  jsld_pkg::t_ctx                        i_ctx,
    input  logic [LENGTH_BITS-1:0]                i_count,
    input  logic [jsld_pkg::CFG_W-1:0]            i_max,
    input  logic                                  i_op,
    input  logic [7:0]                            i_byte,
    output jsld_pkg::t_ctx                        o_ctx,
    output logic [LENGTH_BITS-1:0]                o_count,
    output jsld_pkg::t_result [jsld_pkg::MAX_RESULTS-1:0] o_res,
    output logic [jsld_pkg::RES_CNT_W-1:0]        o_res_cnt
);
    import jsld_pkg::*;

    localparam int SUM_W = LENGTH_BITS + 1;
    localparam int CMP_W = (SUM_W > CFG_W) ? SUM_W : CFG_W;

    t_ctx                  pre;
    logic                  emit_st;
    t_status               st_code;
    logic                  st_zero_len;
    logic                  emit_raw;
    logic [7:0]            raw_byte;
    logic                  emit_cp;
    logic [20:0]           cp;
    logic                  open_str;
    logic [4:0]            hexd;
    logic [15:0]           hv_new;
    t_enc                  enc;
    logic [3:0][7:0]       bytes;
    logic [RES_CNT_W-1:0]  nbytes;
    t_utf                  utf_chain;
    logic [SUM_W-1:0]      sum;
    logic                  sat;
    logic [LENGTH_BITS-1:0] cnt_new;
    logic                  tl_new;

    assign hexd   = hex_digit(i_byte);
    assign hv_new = {i_ctx.hex_val[11:0], hexd[3:0]};
    assign enc    = utf8_encode(cp);

    // Next mode and the decision of what this beat produces.
    always_comb begin
        pre         = i_ctx;
        emit_st     = 1'b0;
        st_code     = ST_OK;
        st_zero_len = 1'b0;
        emit_raw    = 1'b0;
        raw_byte    = i_byte;
        emit_cp     = 1'b0;
        cp          = 21'd0;
        open_str    = 1'b0;
        if (i_op == OP_END) begin
            emit_st = 1'b1;
            unique case (i_ctx.mode)
                M_IDLE: begin
                    st_code     = ST_NO_QUOTE;
                    st_zero_len = 1'b1;
                end
                M_BODY, M_ESC: st_code = ST_UNTERM;
                M_HEX:         st_code = ST_BAD_HEX;
                default:       st_code = ST_UTF8;
            endcase
        end else begin
            unique case (i_ctx.mode)
                M_BODY: begin
                    if (i_byte == CH_QUOTE) begin
                        emit_st = 1'b1;
                        if (i_ctx.utf.bad || i_ctx.utf.need != 2'd0) begin
                            st_code = ST_UTF8;
                        end else if (i_ctx.too_long) begin
                            st_code = ST_TOO_LONG;
                        end else begin
                            st_code = ST_OK;
                        end
                    end else if (i_byte == CH_BSLASH) begin
                        pre.mode = M_ESC;
                    end else if (i_byte < CH_CTRL_LIM) begin
                        emit_st = 1'b1;
                        st_code = ST_CONTROL;
                    end else begin
                        emit_raw = 1'b1;
                    end
                end
                M_ESC: begin
                    pre.mode = M_BODY;
                    unique case (i_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: emit_raw = 1'b1;
                        CH_LOW_B: begin emit_raw = 1'b1; raw_byte = CH_BS;  end
                        CH_LOW_F: begin emit_raw = 1'b1; raw_byte = CH_FF;  end
                        CH_LOW_N: begin emit_raw = 1'b1; raw_byte = CH_LF;  end
                        CH_LOW_R: begin emit_raw = 1'b1; raw_byte = CH_CR;  end
                        CH_LOW_T: begin emit_raw = 1'b1; raw_byte = CH_TAB; end
                        CH_LOW_U: begin
                            pre.mode    = M_HEX;
                            pre.hex_cnt = 2'd0;
                            pre.hex_val = 16'd0;
                        end
                        default: begin
                            emit_st = 1'b1;
                            st_code = ST_BAD_ESC;
                        end
                    endcase
                end
                M_HEX, M_LOW_HEX: begin
                    if (!hexd[4]) begin
                        emit_st = 1'b1;
                        st_code = (i_ctx.mode == M_HEX) ? ST_BAD_HEX : ST_UTF8;
                    end else begin
                        pre.hex_val = hv_new;
                        if (i_ctx.hex_cnt != 2'd3) begin
                            pre.hex_cnt = i_ctx.hex_cnt + 2'd1;
                        end else begin
                            pre.hex_cnt = 2'd0;
                            if (i_ctx.mode == M_HEX) begin
                                if (hv_new[15:10] == 6'b110110) begin
                                    pre.high = hv_new[9:0];
                                    pre.mode = M_WANT_BS;
                                end else if (hv_new[15:10] == 6'b110111) begin
                                    emit_st = 1'b1;
                                    st_code = ST_UTF8;
                                end else begin
                                    pre.mode = M_BODY;
                                    emit_cp  = 1'b1;
                                    cp       = {5'd0, hv_new};
                                end
                            end else begin
                                if (hv_new[15:10] != 6'b110111) begin
                                    emit_st = 1'b1;
                                    st_code = ST_UTF8;
                                end else begin
                                    pre.mode = M_BODY;
                                    emit_cp  = 1'b1;
                                    cp = 21'h010000 + {1'b0, i_ctx.high, hv_new[9:0]};
                                end
                            end
                        end
                    end
                end
                M_WANT_BS: begin
                    if (i_byte == CH_BSLASH) begin
                        pre.mode = M_WANT_U;
                    end else begin
                        emit_st = 1'b1;
                        st_code = ST_UTF8;
                    end
                end
                M_WANT_U: begin
                    if (i_byte == CH_LOW_U) begin
                        pre.mode    = M_LOW_HEX;
                        pre.hex_cnt = 2'd0;
                        pre.hex_val = 16'd0;
                    end else begin
                        emit_st = 1'b1;
                        st_code = ST_UTF8;
                    end
                end
                default: begin
                    if (i_byte == CH_QUOTE) begin
                        open_str = 1'b1;
                    end else begin
                        emit_st     = 1'b1;
                        st_code     = ST_NO_QUOTE;
                        st_zero_len = 1'b1;
                    end
                end
            endcase
        end
    end

    // Emitted bytes, validator, length accounting and the result group.
    always_comb begin
        bytes  = '0;
        nbytes = '0;
        if (emit_raw) begin
            bytes[0] = raw_byte;
            nbytes   = 3'd1;
        end else if (emit_cp) begin
            bytes  = enc.b;
            nbytes = enc.n;
        end

        utf_chain = pre.utf;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (RES_CNT_W'(i) < nbytes) begin
                utf_chain = utf_step(utf_chain, bytes[i]);
            end
        end

        // Counts only grow, so checking the final count covers every byte of the beat.
        sum     = {1'b0, i_count} + SUM_W'(nbytes);
        sat     = sum[LENGTH_BITS];
        cnt_new = sat ? {LENGTH_BITS{1'b1}} : sum[LENGTH_BITS-1:0];
        tl_new  = pre.too_long
                  | ((nbytes != '0) && (sat || (CMP_W'(cnt_new) > CMP_W'(i_max))));

        if (emit_st || open_str) begin
            o_ctx      = CTX_CLEAR;
            o_ctx.mode = open_str ? M_BODY : M_IDLE;
            o_count    = '0;
        end else begin
            o_ctx          = pre;
            o_ctx.utf      = utf_chain;
            o_ctx.too_long = tl_new;
            o_count        = cnt_new;
        end

        for (int i = 0; i < MAX_RESULTS; i++) begin
            o_res[i] = '{kind: K_BYTE, data: bytes[i], status: ST_OK, length: '0};
        end
        if (emit_st) begin
            o_res[0] = '{kind: K_STATUS, data: 8'd0, status: st_code,
                         length: st_zero_len ? '0 : LEN_W'(i_count)};
            o_res_cnt = 3'd1;
        end else begin
            o_res_cnt = nbytes;
        end
    end

endmodule

/* src/json_string_literal_decoder.sv */
// Top level of the JSON string literal decoder: context registers, result buffer, ports.
// Depends on jsld_pkg and jsld_step.

// Feed the raw bytes of one JSON string literal, starting at its opening quote, one
// beat per cycle; a beat with i_op high marks the end of input. Each beat is decoded
// in the cycle it is accepted and its results (zero to four: decoded UTF-8 bytes, or
// one final status) land in a four-entry result buffer that drains one beat per cycle
// while i_out_stall is low. A new beat is taken while the last result of the previous
// one leaves, so the single output port sets the pace: input stalls until every result
// of the current beat has gone out. The final status carries a code and the
// decoded length; bytes already passed on for a string whose status is not zero must
// be discarded downstream. The length limit is written over the configuration channel,
// which is always ready and should be used only while no beat is in flight.
module json_string_literal_decoder #(
    parameter int LENGTH_BITS = jsld_pkg::LENGTH_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_op,
    input  logic [7:0]                      i_in_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_kind,
    output logic [7:0]                      o_out_byte,
    output logic [2:0]                      o_status,
    output logic [jsld_pkg::LEN_W-1:0]      o_length,
    output logic                            o_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [jsld_pkg::CFG_W-1:0]      i_cfg_max_string_bytes
);
    import jsld_pkg::*;

    t_ctx                              r_ctx;
    logic [LENGTH_BITS-1:0]            r_count;
    logic [CFG_W-1:0]                  r_max;
    t_result [MAX_RESULTS-1:0]         r_res;
    logic [RES_CNT_W-1:0]              r_res_cnt;
    logic [RES_IDX_W-1:0]              r_res_idx;

    t_ctx                              n_ctx;
    logic [LENGTH_BITS-1:0]            n_count;
    t_result [MAX_RESULTS-1:0]         n_res;
    logic [RES_CNT_W-1:0]              n_res_cnt;

    t_result                           cur;
    logic                              out_fire;
    logic                              in_accept;

    jsld_step #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_step (
        .i_ctx     (r_ctx),
        .i_count   (r_count),
        .i_max     (r_max),
        .i_op      (i_op),
        .i_byte    (i_in_byte),
        .o_ctx     (n_ctx),
        .o_count   (n_count),
        .o_res     (n_res),
        .o_res_cnt (n_res_cnt)
    );

    assign cur         = r_res[r_res_idx];
    assign o_out_valid = (r_res_cnt != '0);
    assign o_last      = ({1'b0, r_res_idx} == (r_res_cnt - 3'd1));
    assign o_kind      = cur.kind;
    assign o_out_byte  = cur.data;
    assign o_status    = cur.status;
    assign o_length    = cur.length;
    assign o_cfg_ready = 1'b1;

    assign out_fire   = o_out_valid && !i_out_stall;
    // The buffer frees up in the same cycle its last result beat leaves.
    assign o_in_stall = o_out_valid && !(out_fire && o_last);
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx     <= CTX_CLEAR;
            r_count   <= '0;
            r_max     <= MAX_BYTES_RESET;
            r_res_cnt <= '0;
            r_res_idx <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_max_string_bytes;
            end
            if (in_accept) begin
                r_ctx     <= n_ctx;
                r_count   <= n_count;
                r_res_cnt <= n_res_cnt;
                r_res_idx <= '0;
            end else if (out_fire) begin
                if (o_last) begin
                    r_res_cnt <= '0;
                    r_res_idx <= '0;
                end else begin
                    r_res_idx <= r_res_idx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= n_res;
        end
    end

endmodule
